FILE: design/trqs_pkg.sv
`timescale 1ns / 1ps

package trqs_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned CID_W    = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 3'd0,
    REQ_YIELD  = 3'd1,
    REQ_EXIT   = 3'd2,
    REQ_JOIN   = 3'd3,
    REQ_WAIT   = 3'd4,
    REQ_SIGNAL = 3'd5,
    REQ_INIT   = 3'd6
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_READY    = 2'd1,
    ST_JOIN_DONE   = 2'd2,
    ST_SIGNAL_IDLE = 2'd3
  } status_e;

  typedef struct packed {
    logic latch;
    logic busy;
    logic commit;
    logic second;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sig_pending;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: design/trqs_ram.sv
`timescale 1ns / 1ps

module trqs_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/trqs_ctrl.sv
`timescale 1ns / 1ps

module trqs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  trqs_pkg::dp_stat_t   stat_i,
  output trqs_pkg::ctrl_cmd_t  cmd_o
);

  import trqs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SIGNAL
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.busy = 1'b1;
        if (stat_i.sig_pending) begin
          state_d = S_SIGNAL;
        end else if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SIGNAL: begin
        cmd_o.busy   = 1'b1;
        cmd_o.second = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/trqs_dp.sv
`timescale 1ns / 1ps

module trqs_dp #(
  parameter int unsigned MAX_THREADS = 16,
  parameter int unsigned MAX_CONDS   = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [trqs_pkg::REQ_W-1:0]     req_type_i,
  input  logic [trqs_pkg::ID_W-1:0]      thread_id_i,
  input  logic [trqs_pkg::CID_W-1:0]     cond_id_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [trqs_pkg::ID_W-1:0]      running_id_o,
  output logic                           running_valid_o,
  output logic                           switched_o,
  output logic [trqs_pkg::STATUS_W-1:0]  status_o,
  input  trqs_pkg::ctrl_cmd_t            cmd_i,
  output trqs_pkg::dp_stat_t             stat_o
);

  import trqs_pkg::*;

  localparam int unsigned TW = $clog2(MAX_THREADS);
  localparam int unsigned CW = (MAX_CONDS > 1) ? $clog2(MAX_CONDS) : 1;

  req_e                  req_q;
  logic [ID_W-1:0]       tid_q;
  logic [CID_W-1:0]      cid_q;
  logic                  tid_ok, cid_ok;
  logic [TW-1:0]         tid_ix;
  logic [CW-1:0]         cid_ix;

  logic [TW-1:0]         current_q, current_d;
  logic                  present_q, present_d;
  logic [TW-1:0]         ready_first_q, ready_first_d;
  logic [TW-1:0]         ready_last_q, ready_last_d;
  logic                  ready_ne_q, ready_ne_d;
  logic [MAX_CONDS-1:0]  wait_ne_q, wait_ne_d;
  logic [MAX_THREADS-1:0] join_v_q, join_v_d;
  logic [MAX_THREADS-1:0] fin_q, fin_d;

  logic                  out_valid_q;
  logic [ID_W-1:0]       out_id_q;
  logic                  out_rv_q, out_sw_q;
  logic [STATUS_W-1:0]   out_st_q;

  logic                  link_we;
  logic [TW-1:0]         link_wa, link_wd, link_ra, link_rd, link_byp;
  logic                  wait_we;
  logic [2*TW-1:0]       wait_wd, wait_rd;
  logic [CW-1:0]         wait_ra;
  logic [TW-1:0]         wait_first_rd, wait_last_rd;
  logic                  join_we;
  logic [TW-1:0]         join_rd;

  logic                  push_r, pop;
  logic [TW-1:0]         push_val;
  logic [TW-1:0]         rf1, rl1;
  logic                  rne1;
  status_e               status;

  assign tid_ok = (int'(tid_q) < int'(MAX_THREADS));
  assign cid_ok = (int'(cid_q) < int'(MAX_CONDS));
  assign tid_ix = TW'(tid_q);
  assign cid_ix = CW'(cid_q);

  assign wait_first_rd = wait_rd[2*TW-1:TW];
  assign wait_last_rd  = wait_rd[TW-1:0];

  assign wait_ra = cmd_i.busy ? cid_ix : CW'(cond_id_i);
  assign link_ra = (cmd_i.busy && (req_q == REQ_SIGNAL)) ? wait_first_rd : ready_first_q;

  trqs_ram #(.WIDTH(TW), .DEPTH(MAX_THREADS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_wa),
    .wdata_i (link_wd),
    .raddr_i (link_ra),
    .rdata_o (link_rd)
  );

  trqs_ram #(.WIDTH(2 * TW), .DEPTH(MAX_CONDS)) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (wait_we),
    .waddr_i (cid_ix),
    .wdata_i (wait_wd),
    .raddr_i (wait_ra),
    .rdata_o (wait_rd)
  );

  trqs_ram #(.WIDTH(TW), .DEPTH(MAX_THREADS)) u_join_ram (
    .clk_i   (clk_i),
    .we_i    (join_we),
    .waddr_i (tid_ix),
    .wdata_i (current_q),
    .raddr_i (current_q),
    .rdata_o (join_rd)
  );

  assign stat_o.sig_pending = (req_q == REQ_SIGNAL) && cid_ok && wait_ne_q[cid_ix];
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    current_d     = current_q;
    present_d     = present_q;
    wait_ne_d     = wait_ne_q;
    join_v_d      = join_v_q;
    fin_d         = fin_q;
    push_r        = 1'b0;
    push_val      = current_q;
    pop           = 1'b0;
    status        = ST_OK;
    link_we       = 1'b0;
    link_wa       = ready_last_q;
    link_wd       = '0;
    wait_we       = 1'b0;
    wait_wd       = {current_q, current_q};
    join_we       = 1'b0;

    if (cmd_i.commit && !cmd_i.second) begin
      case (req_q)
        REQ_CREATE: begin
          if (tid_ok) begin
            fin_d[tid_ix]    = 1'b0;
            join_v_d[tid_ix] = 1'b0;
            push_r           = 1'b1;
            push_val         = tid_ix;
          end
        end
        REQ_YIELD: begin
          push_r = present_q;
          pop    = 1'b1;
        end
        REQ_EXIT: begin
          if (present_q) begin
            push_r              = join_v_q[current_q];
            push_val            = join_rd;
            join_v_d[current_q] = 1'b0;
            fin_d[current_q]    = 1'b1;
          end
          pop = 1'b1;
        end
        REQ_JOIN: begin
          if (tid_ok) begin
            if (fin_q[tid_ix]) begin
              status = ST_JOIN_DONE;
            end else begin
              if (present_q) begin
                join_v_d[tid_ix] = 1'b1;
                join_we          = 1'b1;
              end
              pop = 1'b1;
            end
          end
        end
        REQ_WAIT: begin
          if (cid_ok) begin
            if (present_q) begin
              wait_we = 1'b1;
              if (wait_ne_q[cid_ix]) begin
                link_we = 1'b1;
                link_wa = wait_last_rd;
                link_wd = current_q;
                wait_wd = {wait_first_rd, current_q};
              end
              wait_ne_d[cid_ix] = 1'b1;
            end
            pop = 1'b1;
          end
        end
        REQ_SIGNAL: begin
          if (cid_ok) begin
            status = ST_SIGNAL_IDLE;
          end
        end
        REQ_INIT: begin
          if (cid_ok) begin
            wait_ne_d[cid_ix] = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.commit && cmd_i.second) begin
      if (wait_first_rd == wait_last_rd) begin
        wait_ne_d[cid_ix] = 1'b0;
      end else begin
        wait_we = 1'b1;
        wait_wd = {link_rd, wait_last_rd};
      end
      push_r   = 1'b1;
      push_val = wait_first_rd;
    end

    rf1  = ready_first_q;
    rl1  = ready_last_q;
    rne1 = ready_ne_q;
    if (push_r) begin
      if (ready_ne_q) begin
        link_we = 1'b1;
        link_wa = ready_last_q;
        link_wd = push_val;
      end else begin
        rf1 = push_val;
      end
      rl1  = push_val;
      rne1 = 1'b1;
    end

    link_byp      = (link_we && (link_wa == rf1)) ? link_wd : link_rd;
    ready_first_d = rf1;
    ready_last_d  = rl1;
    ready_ne_d    = rne1;

    if (pop) begin
      if (rne1) begin
        current_d = rf1;
        present_d = 1'b1;
        if (rf1 == rl1) begin
          ready_ne_d = 1'b0;
        end else begin
          ready_first_d = link_byp;
        end
      end else begin
        current_d = '0;
        present_d = 1'b0;
        status    = ST_NO_READY;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_e'(req_type_i);
      tid_q <= thread_id_i;
      cid_q <= cond_id_i;
    end
    if (cmd_i.commit) begin
      out_id_q <= present_d ? ID_W'(current_d) : '0;
      out_rv_q <= present_d;
      out_sw_q <= (present_q != present_d) ||
                  (present_q && present_d && (current_q != current_d));
      out_st_q <= status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_q     <= '0;
      present_q     <= 1'b1;
      ready_first_q <= '0;
      ready_last_q  <= '0;
      ready_ne_q    <= 1'b0;
      wait_ne_q     <= '0;
      join_v_q      <= '0;
      fin_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        current_q     <= current_d;
        present_q     <= present_d;
        ready_first_q <= ready_first_d;
        ready_last_q  <= ready_last_d;
        ready_ne_q    <= ready_ne_d;
        wait_ne_q     <= wait_ne_d;
        join_v_q      <= join_v_d;
        fin_q         <= fin_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign running_id_o    = out_id_q;
  assign running_valid_o = out_rv_q;
  assign switched_o      = out_sw_q;
  assign status_o        = out_st_q;

endmodule

FILE: design/thread_ready_queue_scheduler_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Beat contents
// request   in         in_valid_i / in_ready_o   req_type_i, thread_id_i, cond_id_i
// result    out        out_valid_o / out_ready_i running_id_o, running_valid_o,
//                                                switched_o, status_o
//
// Each request passes through S_EXEC, and a condition signal on a non-empty queue also through
// S_SIGNAL, because the link table is a memory with a registered read port and a signal must
// read the link of the condition queue's head before moving it to the ready queue.
// The reset is asynchronous and active low; all queues start empty with thread zero running.
// A result waiting in the output register does not block acceptance of the next request,
// which then holds in its final cycle until the output register frees.

module thread_ready_queue_scheduler_core #(
  parameter int unsigned MAX_THREADS = 16,
  parameter int unsigned MAX_CONDS   = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [trqs_pkg::REQ_W-1:0]     req_type_i,
  input  logic [trqs_pkg::ID_W-1:0]      thread_id_i,
  input  logic [trqs_pkg::CID_W-1:0]     cond_id_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [trqs_pkg::ID_W-1:0]      running_id_o,
  output logic                           running_valid_o,
  output logic                           switched_o,
  output logic [trqs_pkg::STATUS_W-1:0]  status_o
);

  import trqs_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  trqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  trqs_dp #(
    .MAX_THREADS (MAX_THREADS),
    .MAX_CONDS   (MAX_CONDS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_type_i      (req_type_i),
    .thread_id_i     (thread_id_i),
    .cond_id_i       (cond_id_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .running_id_o    (running_id_o),
    .running_valid_o (running_valid_o),
    .switched_o      (switched_o),
    .status_o        (status_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule

FILE: design/trqs_checker.sv
`timescale 1ns / 1ps

module trqs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [trqs_pkg::ID_W-1:0]      running_id_i,
  input logic                           running_valid_i,
  input logic                           switched_i,
  input logic [trqs_pkg::STATUS_W-1:0]  status_i
);

  import trqs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(running_id_i) &&
      $stable(running_valid_i) && $stable(switched_i) && $stable(status_i))
    else $error("Result beat changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("Request accepted while the previous one was still in progress.");

  a_idle_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !running_valid_i |-> running_id_i == '0)
    else $error("Running thread reported while no thread runs.");

  a_no_switch_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_JOIN_DONE || status_i == ST_SIGNAL_IDLE) |-> !switched_i)
    else $error("Switch reported for a request that changes no running thread.");

  a_no_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_NO_READY |-> !running_valid_i)
    else $error("Thread reported running after an empty dispatch.");

endmodule

bind thread_ready_queue_scheduler_core trqs_checker u_trqs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_i      (in_ready_o),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .running_id_i    (running_id_o),
  .running_valid_i (running_valid_o),
  .switched_i      (switched_o),
  .status_i        (status_o)
);
